/* rtl/max_weight_unit_scheduler_defines.svh */
// Assertion helpers for the scheduler, compiled away for synthesis.
`ifndef MAX_WEIGHT_UNIT_SCHEDULER_DEFINES_SVH
`define MAX_WEIGHT_UNIT_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define MWUS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MWUS_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`else

`define MWUS_ASSERT(name, prop, msg)
`define MWUS_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

/* rtl/mwus_pkg.sv */
package mwus_pkg;

   localparam int MAX_JOBS = 256;
   localparam int IDX_W    = $clog2(MAX_JOBS);
   localparam int CNT_W    = IDX_W + 1;

   localparam int FUNC_W   = 2;
   localparam int JOB_W    = 8;
   localparam int WEIGHT_W = 16;
   localparam int UNITS_W  = 16;
   localparam int PROD_W   = WEIGHT_W + UNITS_W;
   localparam int COST_W   = 40;

   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FREE,
      ST_BEST,
      ST_COMMIT,
      ST_RESP
   } mwus_state_type;

   // one job table entry
   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic [JOB_W-1:0]    job;
      logic [UNITS_W-1:0]  units;
   } mwus_entry_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;        // capture the accepted beat
      logic cnt_step;     // advance the slot counter
      logic scan_issue;   // read the slot under the counter for the best search
      logic add_commit;   // store the new job at the counter slot
      logic set_ovf;      // table full, flag the add
      logic tick_commit;  // serve one unit of the best job
      logic load_rsp;     // move the result into the output register
   } mwus_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              count_zero;
      logic              cnt_done;
      logic              slot_free;
   } mwus_stat_type;

endpackage

/* rtl/mwus_if.sv */
interface mwus_req_if import mwus_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [JOB_W-1:0]    job_id;
   logic [WEIGHT_W-1:0] weight;
   logic [UNITS_W-1:0]  unit_count;

   modport source (output valid, output func, output job_id, output weight,
                   output unit_count, input ready);
   modport sink   (input valid, input func, input job_id, input weight,
                   input unit_count, output ready);
endinterface

interface mwus_rsp_if import mwus_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              served_valid;
   logic [JOB_W-1:0]  served_job;
   logic [COST_W-1:0] remaining_cost;
   logic              overflow;

   modport source (output valid, output served_valid, output served_job,
                   output remaining_cost, output overflow, input ready);
   modport sink   (input valid, input served_valid, input served_job,
                   input remaining_cost, input overflow, output ready);
endinterface

/* rtl/mwus_datapath.sv */
`include "max_weight_unit_scheduler_defines.svh"

module mwus_datapath import mwus_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [JOB_W-1:0]    req_job_id,
   input  logic [WEIGHT_W-1:0] req_weight,
   input  logic [UNITS_W-1:0]  req_unit_count,
   input  mwus_cmd_type  cmd,
   output mwus_stat_type stat,
   output logic              rsp_served_valid,
   output logic [JOB_W-1:0]  rsp_served_job,
   output logic [COST_W-1:0] rsp_remaining_cost,
   output logic              rsp_overflow
);

   // latched beat
   logic [FUNC_W-1:0]   func_ff;
   logic [JOB_W-1:0]    job_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [UNITS_W-1:0]  count_ff;
   logic [PROD_W-1:0]   product_ff;

   // job table
   mwus_entry_type      entry_mem [MAX_JOBS];
   logic [MAX_JOBS-1:0] valid_ff;
   logic [COST_W-1:0]   cost_ff;

   // slot counter and search pipeline
   logic [CNT_W-1:0]    cnt_ff;
   logic [IDX_W-1:0]    cnt_idx;
   mwus_entry_type      rd_ff;
   logic                pipe_live_ff;
   logic [IDX_W-1:0]    pipe_idx_ff;

   logic                found_ff;
   mwus_entry_type      best_ff;
   logic [IDX_W-1:0]    best_idx_ff;
   logic                take_rd;

   // staged result flags
   logic                served_ff;
   logic [JOB_W-1:0]    served_job_ff;
   logic                ovf_ff;

   // memory write port
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   mwus_entry_type      mem_wdata;

   assign cnt_idx = cnt_ff[IDX_W-1:0];

   assign stat.func       = func_ff;
   assign stat.count_zero = (count_ff == '0);
   assign stat.cnt_done   = (cnt_ff == CNT_W'(MAX_JOBS));
   assign stat.slot_free  = !valid_ff[cnt_idx];

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff    <= req_func;
         job_ff     <= req_job_id;
         weight_ff  <= req_weight;
         count_ff   <= req_unit_count;
         product_ff <= req_weight * req_unit_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.latch) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_step) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // write mux: new job at the counter slot, or the served job written back
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_idx;
      mem_wdata = '{weight: weight_ff, job: job_ff, units: count_ff};
      if (cmd.add_commit) begin
         mem_we = 1'b1;
      end else if (cmd.tick_commit && found_ff) begin
         mem_we          = 1'b1;
         mem_waddr       = best_idx_ff;
         mem_wdata       = best_ff;
         mem_wdata.units = best_ff.units - UNITS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_issue) begin
         rd_ff <= entry_mem[cnt_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_live_ff <= 1'b0;
      end else begin
         pipe_live_ff <= cmd.scan_issue && valid_ff[cnt_idx];
      end
      pipe_idx_ff <= cnt_idx;
   end

   // ascending scan with >= keeps the highest slot among equal keys
   assign take_rd = pipe_live_ff &&
                    (!found_ff || {rd_ff.weight, rd_ff.job} >= {best_ff.weight, best_ff.job});

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.latch) begin
         found_ff <= 1'b0;
      end else if (take_rd) begin
         found_ff <= 1'b1;
      end
      if (take_rd) begin
         best_ff     <= rd_ff;
         best_idx_ff <= pipe_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cost_ff  <= '0;
      end else if (cmd.load_rsp && func_ff == FUNC_REPORT) begin
         valid_ff <= '0;
         cost_ff  <= '0;
      end else if (cmd.add_commit) begin
         valid_ff[cnt_idx] <= 1'b1;
         cost_ff           <= cost_ff + COST_W'(product_ff);
      end else if (cmd.tick_commit && found_ff) begin
         if (best_ff.units == UNITS_W'(1)) begin
            valid_ff[best_idx_ff] <= 1'b0;
         end
         cost_ff <= cost_ff - COST_W'(best_ff.weight);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         served_ff     <= 1'b0;
         served_job_ff <= '0;
         ovf_ff        <= 1'b0;
      end else begin
         if (cmd.set_ovf) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.tick_commit && found_ff) begin
            served_ff     <= 1'b1;
            served_job_ff <= best_ff.job;
         end
      end
   end

   // report returns the cost as it stands before the clear in the same cycle
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_served_valid   <= served_ff;
         rsp_served_job     <= served_job_ff;
         rsp_remaining_cost <= cost_ff;
         rsp_overflow       <= ovf_ff;
      end
   end

   `MWUS_ASSERT(a_scan_table_stable, cmd.scan_issue |=> $stable(valid_ff), "table changed during search")
   `MWUS_ASSERT(a_serve_live_entry, (cmd.tick_commit && found_ff) |-> valid_ff[best_idx_ff], "served a free slot")
   `MWUS_ASSERT(a_add_free_slot, cmd.add_commit |-> (stat.slot_free && !stat.cnt_done), "add into a used slot")
   `MWUS_ASSERT(a_report_clears, (cmd.load_rsp && func_ff == FUNC_REPORT) |=> (valid_ff == '0 && cost_ff == '0), "report left state behind")

endmodule

/* rtl/mwus_ctrl.sv */
`include "max_weight_unit_scheduler_defines.svh"

module mwus_ctrl import mwus_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  mwus_stat_type stat,
   output mwus_cmd_type  cmd
);

   mwus_state_type state_ff, state_in;
   logic           out_full_ff, out_full_in;
   logic           out_free;

   assign out_free = !out_full_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         out_full_ff <= out_full_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (stat.func)
               FUNC_ADD:  state_in = stat.count_zero ? ST_RESP : ST_FREE;
               FUNC_TICK: state_in = ST_BEST;
               default:   state_in = ST_RESP;
            endcase
         end
         ST_FREE: begin
            if (stat.cnt_done || stat.slot_free) state_in = ST_RESP;
         end
         ST_BEST: begin
            if (stat.cnt_done) state_in = ST_COMMIT;
         end
         ST_COMMIT: state_in = ST_RESP;
         ST_RESP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         ST_DECODE: ;
         ST_FREE: begin
            if (stat.cnt_done) begin
               cmd.set_ovf = 1'b1;
            end else if (stat.slot_free) begin
               cmd.add_commit = 1'b1;
            end else begin
               cmd.cnt_step = 1'b1;
            end
         end
         ST_BEST: begin
            cmd.scan_issue = !stat.cnt_done;
            cmd.cnt_step   = !stat.cnt_done;
         end
         ST_COMMIT: cmd.tick_commit = 1'b1;
         ST_RESP:   cmd.load_rsp    = out_free;
         default: ;
      endcase
   end

   always_comb begin
      out_full_in = out_full_ff;
      if (cmd.load_rsp) begin
         out_full_in = 1'b1;
      end else if (rsp_ready) begin
         out_full_in = 1'b0;
      end
   end

   assign rsp_valid = out_full_ff;

   `MWUS_ASSERT(a_one_result_per_beat, (cmd.load_rsp && state_ff != ST_RESP) |-> 1'b0, "result loaded outside response")
   `MWUS_ASSERT(a_no_overwrite, cmd.load_rsp |-> (!out_full_ff || rsp_ready), "pending result overwritten")
   `MWUS_ASSERT(a_accept_leaves_idle, (req_valid && req_ready) |=> (state_ff == ST_DECODE), "accepted beat not decoded")

endmodule

/* rtl/max_weight_unit_scheduler.sv */
// Channel  Dir  Beat fields                                        Handshake
// req_bus  in   func, job_id, weight, unit_count                   valid/ready
// rsp_bus  out  served_valid, served_job, remaining_cost, overflow valid/ready
//
// One beat at a time. A report, the spare selector code 3 and a zero-count add go from
// decode straight to the response; an add first scans for the lowest free slot (overflow
// when full); a tick runs the best-job search, reading one slot per cycle, then commits.
// Reset (synchronous, active high) empties the table and zeroes the cost at once.
// A new beat is taken while the previous result still waits in the output register;
// a stalled rsp side only holds the block in its response state.

`include "max_weight_unit_scheduler_defines.svh"

module max_weight_unit_scheduler import mwus_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mwus_req_if.sink  req_bus,
   mwus_rsp_if.source rsp_bus
);

   mwus_cmd_type  cmd;   // controller commands
   mwus_stat_type stat;  // datapath status

   // sequencer: owns the handshakes and the output-register full flag
   mwus_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // job table, cost accumulator, slot search and output register
   mwus_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_func           (req_bus.func),
      .req_job_id         (req_bus.job_id),
      .req_weight         (req_bus.weight),
      .req_unit_count     (req_bus.unit_count),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_served_valid   (rsp_bus.served_valid),
      .rsp_served_job     (rsp_bus.served_job),
      .rsp_remaining_cost (rsp_bus.remaining_cost),
      .rsp_overflow       (rsp_bus.overflow)
   );

   // input is never offered while a search or a commit is running
   `MWUS_ASSERT(a_ready_only_idle, req_bus.ready |-> !(cmd.scan_issue || cmd.tick_commit), "ready during search")

endmodule

/* test/max_weight_unit_scheduler_checker.sv */
module max_weight_unit_scheduler_checker import mwus_pkg::*; (
   input  logic clock,
   input  logic reset,
   mwus_req_if  req_mon,
   mwus_rsp_if  rsp_mon,
   output int   pending_count,
   output int   fail_count
);

   typedef struct packed {
      logic              served_valid;
      logic [JOB_W-1:0]  served_job;
      logic [COST_W-1:0] remaining_cost;
      logic              overflow;
   } outcome_type;

   // shadow job table, only used slots are ever read
   mwus_entry_type    slot_entry [MAX_JOBS];
   bit                slot_used  [MAX_JOBS];
   logic [COST_W-1:0] unserved_cost;
   outcome_type       expected_outcomes [$];
   int                mismatches = 0;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   // queues one expected outcome behind those already waiting
   function automatic void append_outcome(input outcome_type o);
      expected_outcomes.insert(expected_outcomes.size(), o);
   endfunction

   // applies one beat to the shadow table and returns the outcome it should give
   function automatic outcome_type apply_beat(input logic [FUNC_W-1:0]   func,
                                              input logic [JOB_W-1:0]    id,
                                              input logic [WEIGHT_W-1:0] w,
                                              input logic [UNITS_W-1:0]  n);
      outcome_type o;
      int          best;
      bit          found;
      o     = '0;
      best  = 0;
      found = 1'b0;
      case (func)
         FUNC_ADD: begin
            if (n != '0) begin
               for (int i = 0; i < MAX_JOBS; i++) begin
                  if (!found && !slot_used[i]) begin
                     found               = 1'b1;
                     slot_used[i]        = 1'b1;
                     slot_entry[i].job    = id;
                     slot_entry[i].weight = w;
                     slot_entry[i].units  = n;
                     unserved_cost = unserved_cost + COST_W'(w) * COST_W'(n);
                  end
               end
               o.overflow = !found;
            end
         end
         FUNC_TICK: begin
            for (int i = 0; i < MAX_JOBS; i++) begin
               if (slot_used[i] && (!found ||
                   slot_entry[i].weight > slot_entry[best].weight ||
                   (slot_entry[i].weight == slot_entry[best].weight &&
                    slot_entry[i].job >= slot_entry[best].job))) begin
                  best  = i;
                  found = 1'b1;
               end
            end
            if (found) begin
               o.served_valid = 1'b1;
               o.served_job   = slot_entry[best].job;
               unserved_cost  = unserved_cost - COST_W'(slot_entry[best].weight);
               slot_entry[best].units = slot_entry[best].units - UNITS_W'(1);
               if (slot_entry[best].units == '0)
                  slot_used[best] = 1'b0;
            end
         end
         FUNC_REPORT: begin
            o.remaining_cost = unserved_cost;
            foreach (slot_used[i])
               slot_used[i] = 1'b0;
            unserved_cost = '0;
         end
         default: ;
      endcase
      if (func != FUNC_REPORT)
         o.remaining_cost = unserved_cost;
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (reset) begin
         foreach (slot_used[i])
            slot_used[i] = 1'b0;
         unserved_cost = '0;
         expected_outcomes.delete();
      end else begin
         // result side first, so a stray beat is not hidden by a fresh entry
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.served_valid, rsp_mon.served_job,
                   rsp_mon.remaining_cost, rsp_mon.overflow};
            if (expected_outcomes.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               want = expected_outcomes.pop_front();
               if (got.served_valid !== want.served_valid)
                  report_mismatch($sformatf("served_valid got %0b expected %0b",
                                            got.served_valid, want.served_valid));
               if (got.served_job !== want.served_job)
                  report_mismatch($sformatf("served_job got %0d expected %0d",
                                            got.served_job, want.served_job));
               if (got.remaining_cost !== want.remaining_cost)
                  report_mismatch($sformatf("remaining_cost got %0d expected %0d",
                                            got.remaining_cost, want.remaining_cost));
               if (got.overflow !== want.overflow)
                  report_mismatch($sformatf("overflow got %0b expected %0b",
                                            got.overflow, want.overflow));
            end
         end
         if (req_mon.valid && req_mon.ready)
            append_outcome(apply_beat(req_mon.func, req_mon.job_id,
                                      req_mon.weight, req_mon.unit_count));
      end
      pending_count <= expected_outcomes.size();
   end

endmodule

/* test/tb_max_weight_unit_scheduler.sv */
module tb_max_weight_unit_scheduler;
   import mwus_pkg::*;

   // selector code 3 has no name in the package; it must leave state alone
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

   localparam int RANDOM_BEATS   = 120;
   localparam int HOLDOFF_CYCLES = 3000;
   // a tick scans the whole table, so allow a couple of full scans at the end
   localparam int TAIL_CYCLES    = 2 * MAX_JOBS + 50;
   // worst case is roughly 400 beats, each no longer than a full-table tick, plus long gaps on
   // both sides and the hold-off; this sits several times above that
   localparam int CYCLE_LIMIT    = 1_500_000;

   logic clock;
   logic reset;
   int   pending_count;
   int   fail_count;
   int   cycle_count;
   bit   want_holdoff = 1'b0;
   bit   sender_calm  = 1'b0;

   mwus_req_if req_bus ();
   mwus_rsp_if rsp_bus ();

   max_weight_unit_scheduler u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // watches both channels, keeps its own job table and compares each result
   max_weight_unit_scheduler_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .pending_count (pending_count),
      .fail_count    (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle lengths: mostly none or short, now and then a long one
   function automatic int pick_idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 80);
   endfunction

   // Offers one beat and returns at the edge that takes it. Valid is only
   // dropped when an idle gap goes in, so back-to-back beats keep it high.
   task automatic send_beat(input logic [FUNC_W-1:0]   func,
                            input logic [JOB_W-1:0]    id,
                            input logic [WEIGHT_W-1:0] w,
                            input logic [UNITS_W-1:0]  n);
      int idle;
      idle = sender_calm ? 0 : pick_idle_len();
      if (idle > 0) begin
         req_bus.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.func       <= func;
      req_bus.job_id     <= id;
      req_bus.weight     <= w;
      req_bus.unit_count <= n;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Sender goes quiet until the checker holds no expectation. One edge is
   // always let pass first, as a beat taken at this edge is not yet counted.
   task automatic wait_all_served();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Random beat: mostly adds and ticks over a handful of ids and weights so
   // that ties and preemption are frequent; full-range values keep every bit
   // moving. Counts are kept small so jobs drain and slots get reused.
   task automatic send_random_beat();
      int                  pick;
      logic [FUNC_W-1:0]   func;
      logic [JOB_W-1:0]    id;
      logic [WEIGHT_W-1:0] w;
      logic [UNITS_W-1:0]  n;
      pick = $urandom_range(0, 99);
      id   = ($urandom_range(0, 3) == 0) ? JOB_W'($urandom) : JOB_W'($urandom_range(0, 7));
      case ($urandom_range(0, 4))
         0: w = '0;
         1: w = '1;
         2: w = WEIGHT_W'($urandom_range(0, 3));
         default: w = WEIGHT_W'($urandom);
      endcase
      n = ($urandom_range(0, 5) == 0) ? UNITS_W'($urandom) : UNITS_W'($urandom_range(1, 3));
      if (pick < 48) begin
         func = FUNC_ADD;
      end else if (pick < 90) begin
         func = FUNC_TICK;
      end else if (pick < 95) begin
         func = FUNC_REPORT;
      end else if (pick < 98) begin
         func = FUNC_SPARE;
      end else begin
         func = FUNC_ADD;
         n    = '0;
      end
      send_beat(func, id, w, n);
   endtask

   // Result side: random ready with stalls, plus one long hold-off counted
   // here once the stimulus asks for it. The sender keeps offering meanwhile,
   // so the output register fills and req ready has to drop.
   initial begin
      bit held;
      int stall;
      held = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         if (want_holdoff && !held) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
            stall = pick_idle_len();
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_count);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.func       = FUNC_ADD;
      req_bus.job_id     = '0;
      req_bus.weight     = '0;
      req_bus.unit_count = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // empty table: nothing to serve, cost stays zero
      send_beat(FUNC_TICK, 8'hA5, 16'h1234, 16'h0007);
      // spare selector with busy fields must change nothing
      send_beat(FUNC_SPARE, '1, '1, '1);
      // zero unit count: ignored, no flag
      send_beat(FUNC_ADD, 8'd5, 16'd100, '0);
      // largest product, then a zero-weight job ranked below everything
      send_beat(FUNC_ADD, 8'd255, '1, '1);
      send_beat(FUNC_ADD, 8'd0, '0, 16'd1);
      // equal weight, lower id; then equal weight and equal id in a higher slot
      send_beat(FUNC_ADD, 8'd10, '1, 16'd2);
      send_beat(FUNC_ADD, 8'd255, '1, 16'd3);
      repeat (4) send_beat(FUNC_TICK, '0, '0, '0);
      // spare code with a loaded table carries the live cost
      send_beat(FUNC_SPARE, 8'h5A, 16'hA5A5, 16'h5A5A);
      send_beat(FUNC_REPORT, '0, '0, '0);
      send_beat(FUNC_REPORT, '1, '1, '1);
      // two zero-weight jobs, tie on weight broken by id, then empty again
      send_beat(FUNC_ADD, 8'd3, '0, 16'd1);
      send_beat(FUNC_ADD, 8'd7, '0, 16'd1);
      repeat (3) send_beat(FUNC_TICK, '1, '1, '1);
      wait_all_served();

      // --- full table: every slot taken, then overflow and a zero count ---
      for (int i = 0; i < MAX_JOBS; i++)
         send_beat(FUNC_ADD, JOB_W'($urandom),
                   (i < 8) ? '1 : WEIGHT_W'($urandom),
                   (i < 8) ? '1 : UNITS_W'($urandom_range(1, 65535)));
      send_beat(FUNC_ADD, 8'd42, '1, '1);
      send_beat(FUNC_ADD, 8'd43, '1, '0);
      repeat (2) send_beat(FUNC_TICK, '0, '0, '0);
      send_beat(FUNC_ADD, 8'd44, 16'd9, 16'd2);
      send_beat(FUNC_REPORT, '0, '0, '0);
      wait_all_served();

      // --- random ---
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i == 30)
            want_holdoff <= 1'b1;
         if (i == 50)
            sender_calm = 1'b1;
         if (i == 80)
            sender_calm = 1'b0;
         if (i == 90)
            wait_all_served();
         send_random_beat();
      end

      wait_all_served();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
